@@ design/assert_macros.svh @@
// Assertion macros shared by the RTL; empty bodies when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a condition implies another in the same cycle
`define PFL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");
// Check that a condition implies another in the next cycle
`define PFL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");
`else
`define PFL_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define PFL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ design/pfl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package pfl_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   localparam logic [31:0] MS_PER_SEC = 32'd1000;
   localparam logic [15:0] HIT_MAX = 16'hFFFF;

   // Register map
   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_SECONDS  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_SECONDS = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HIT_LIMIT      = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_IDLE_SECONDS   = 8'd3;

   // Actions
   localparam logic ACT_NOTE  = 1'b0;
   localparam logic ACT_CHECK = 1'b1;

   typedef struct packed {
      logic [15:0] block_seconds;
      logic [15:0] window_seconds;
      logic [15:0] hit_limit;
      logic [15:0] idle_seconds;
   } cfg_type;

   // Per-source record held in the record memory
   typedef struct packed {
      logic [15:0] hit_count;
      logic [31:0] first_time;
      logic [31:0] last_time;
      logic        blocked;
      logic [31:0] block_time;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   // Result of an address scan
   typedef struct packed {
      logic             done;
      logic             hit;
      logic [IDX_W-1:0] idx;
   } match_type;

   typedef struct packed {
      logic allowed;
      logic newly_blocked;
      logic released;
      logic table_full;
   } rsp_type;

   // Table update and result for one item
   typedef struct packed {
      logic             rec_we;
      logic             addr_we;
      logic             valid_set;
      logic             valid_clr;
      logic [IDX_W-1:0] wr_idx;
      rec_type          rec_wdata;
      rsp_type          rsp;
   } dec_type;

endpackage
`default_nettype wire

@@ design/per_source_flood_limiter_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// One item at a time: a new request is taken only in idle, after the address scan, which reads
// the address memory one entry a cycle, and the update; the next request is taken while a response waits.
// Reset: valid bits cleared, registers back to 60/10/20/60, no memory clearing pass.
module per_source_flood_limiter_top import pfl_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_action,
   input  wire logic [31:0]          req_source_address,
   input  wire logic [31:0]          req_now_ms,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_allowed,
   output logic                      rsp_newly_blocked,
   output logic                      rsp_released,
   output logic                      rsp_table_full,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [15:0]          csr_wdata
);

`include "assert_macros.svh"

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EXEC = 3'b100
   } state_type;

   state_type                state_ff, state_in;
   cfg_type                  cfg_ff, cfg_in;
   logic [TABLE_ENTRIES-1:0] entry_valid_ff, entry_valid_in;
   logic                     act_ff;
   logic [31:0]              addr_ff;
   logic [31:0]              now_ff;
   logic                     hit_ff;
   logic [IDX_W-1:0]         idx_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff;
   logic                     accept;
   logic                     out_free;
   logic                     commit;
   match_type                match_res;
   logic [REC_W-1:0]         rec_rdata;
   rec_type                  rec_rd;
   dec_type                  dec;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign commit    = (state_ff == ST_EXEC) && out_free;

   // Configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_BLOCK_SECONDS:  cfg_in.block_seconds  = csr_wdata;
            REG_WINDOW_SECONDS: cfg_in.window_seconds = csr_wdata;
            REG_HIT_LIMIT:      cfg_in.hit_limit      = csr_wdata;
            REG_IDLE_SECONDS:   cfg_in.idle_seconds   = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.block_seconds  <= 16'd60;
         cfg_ff.window_seconds <= 16'd10;
         cfg_ff.hit_limit      <= 16'd20;
         cfg_ff.idle_seconds   <= 16'd60;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Scan the address memory for the source
   pfl_match u_match (
      .clock       (clock),
      .reset       (reset),
      .start       (accept),
      .key         (addr_ff),
      .entry_valid (entry_valid_ff),
      .addr_we     (commit && dec.addr_we),
      .addr_widx   (dec.wr_idx),
      .addr_wdata  (addr_ff),
      .result      (match_res)
   );

   // Record memory, read once on a hit
   pfl_ram #(.WIDTH(REC_W), .DEPTH(TABLE_ENTRIES)) u_rec_ram (
      .clock (clock),
      .we    (commit && dec.rec_we),
      .waddr (dec.wr_idx),
      .wdata (dec.rec_wdata),
      .re    ((state_ff == ST_SCAN) && match_res.done && match_res.hit),
      .raddr (match_res.idx),
      .rdata (rec_rdata)
   );

   assign rec_rd = rec_type'(rec_rdata);

   pfl_decide u_decide (
      .clock       (clock),
      .cfg         (cfg_ff),
      .action      (act_ff),
      .now_ms      (now_ff),
      .hit         (hit_ff),
      .hit_idx     (idx_ff),
      .rec         (rec_rd),
      .entry_valid (entry_valid_ff),
      .dec         (dec)
   );

   // Sequence one item: scan, then update and respond
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_SCAN;
         ST_SCAN: if (match_res.done) state_in = ST_EXEC;
         ST_EXEC: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Set or drop valid bits on commit
   always_comb begin
      entry_valid_in = entry_valid_ff;
      if (commit && dec.valid_set) begin
         entry_valid_in[dec.wr_idx] = 1'b1;
      end
      if (commit && dec.valid_clr) begin
         entry_valid_in[dec.wr_idx] = 1'b0;
      end
   end

   assign rsp_valid_in = commit ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_valid_ff <= entry_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Hold the item and scan outcome
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff  <= req_action;
         addr_ff <= req_source_address;
         now_ff  <= req_now_ms;
      end
      if ((state_ff == ST_SCAN) && match_res.done) begin
         hit_ff <= match_res.hit;
         idx_ff <= match_res.idx;
      end
      if (commit) begin
         rsp_ff <= dec.rsp;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_allowed       = rsp_ff.allowed;
   assign rsp_newly_blocked = rsp_ff.newly_blocked;
   assign rsp_released      = rsp_ff.released;
   assign rsp_table_full    = rsp_ff.table_full;

   `PFL_ASSERT_NEXT(a_accept_starts_scan, clock, reset, accept, state_ff == ST_SCAN)
   `PFL_ASSERT_IMPLY(a_hit_is_valid, clock, reset, match_res.done && match_res.hit, entry_valid_ff[match_res.idx])
   `PFL_ASSERT_IMPLY(a_block_release_excl, clock, reset, rsp_valid_ff, !(rsp_ff.newly_blocked && rsp_ff.released))
   `PFL_ASSERT_IMPLY(a_full_only_on_note, clock, reset, commit && dec.rsp.table_full, act_ff == ACT_NOTE && !hit_ff)

endmodule
`default_nettype wire

@@ design/pfl_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module pfl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Registered read, hold while not enabled
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

@@ design/pfl_match.sv @@
`timescale 1ns / 1ps
`default_nettype none
module pfl_match import pfl_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [31:0]              key,
   input  wire logic [TABLE_ENTRIES-1:0] entry_valid,
   input  wire logic                     addr_we,
   input  wire logic [IDX_W-1:0]         addr_widx,
   input  wire logic [31:0]              addr_wdata,
   output match_type                     result
);

   logic             issue_ff, issue_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic [31:0]      addr_rdata;
   logic             hit_now;
   logic             done;

   pfl_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_addr_ram (
      .clock (clock),
      .we    (addr_we),
      .waddr (addr_widx),
      .wdata (addr_wdata),
      .re    (issue_ff),
      .raddr (rd_idx_ff),
      .rdata (addr_rdata)
   );

   // Compare the entry read last cycle
   assign hit_now = cmp_vld_ff && entry_valid[cmp_idx_ff] && (addr_rdata == key);
   assign done    = cmp_vld_ff && (hit_now || (cmp_idx_ff == LAST_IDX));

   // Advance the scan one entry a cycle, stop on a hit or after the last entry
   always_comb begin
      issue_in   = issue_ff;
      rd_idx_in  = rd_idx_ff;
      cmp_vld_in = 1'b0;
      cmp_idx_in = cmp_idx_ff;
      if (start) begin
         issue_in  = 1'b1;
         rd_idx_in = '0;
      end else if (done) begin
         issue_in = 1'b0;
      end else if (issue_ff) begin
         cmp_vld_in = 1'b1;
         cmp_idx_in = rd_idx_ff;
         rd_idx_in  = rd_idx_ff + IDX_W'(1);
         if (rd_idx_ff == LAST_IDX) begin
            issue_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff   <= 1'b0;
         cmp_vld_ff <= 1'b0;
      end else begin
         issue_ff   <= issue_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff  <= rd_idx_in;
      cmp_idx_ff <= cmp_idx_in;
   end

   assign result.done = done;
   assign result.hit  = hit_now;
   assign result.idx  = cmp_idx_ff;

endmodule
`default_nettype wire

@@ design/pfl_decide.sv @@
`timescale 1ns / 1ps
`default_nettype none
module pfl_decide import pfl_pkg::*; (
   input  wire logic                     clock,
   input  wire cfg_type                  cfg,
   input  wire logic                     action,
   input  wire logic [31:0]              now_ms,
   input  wire logic                     hit,
   input  wire logic [IDX_W-1:0]         hit_idx,
   input  wire rec_type                  rec,
   input  wire logic [TABLE_ENTRIES-1:0] entry_valid,
   output dec_type                       dec
);

   logic [31:0]      rel_thr_ff, rel_thr_in;
   logic [31:0]      win_thr_ff, win_thr_in;
   logic [31:0]      idle_thr_ff, idle_thr_in;
   logic [31:0]      el_block, el_first, el_last;
   logic             free_any;
   logic [IDX_W-1:0] free_idx;
   rec_type          rec_upd;

   // Turn second limits into millisecond thresholds:
   // whole seconds > B  <=>  ms >= (B + 1) * 1000, whole seconds < W <=> ms < W * 1000
   assign rel_thr_in  = (32'(cfg.block_seconds) + 32'd1) * MS_PER_SEC;
   assign win_thr_in  = 32'(cfg.window_seconds) * MS_PER_SEC;
   assign idle_thr_in = (32'(cfg.idle_seconds) + 32'd1) * MS_PER_SEC;

   always_ff @(posedge clock) begin
      rel_thr_ff  <= rel_thr_in;
      win_thr_ff  <= win_thr_in;
      idle_thr_ff <= idle_thr_in;
   end

   // Elapsed milliseconds, modulo 2^32
   assign el_block = now_ms - rec.block_time;
   assign el_first = now_ms - rec.first_time;
   assign el_last  = now_ms - rec.last_time;

   // Find the lowest free slot
   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (!entry_valid[i]) begin
            free_any = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      rec_upd           = rec;
      dec               = '0;
      dec.wr_idx        = hit_idx;
      dec.rsp.allowed   = 1'b1;
      dec.rec_wdata     = rec;
      if (action == ACT_NOTE) begin
         if (hit) begin
            // Bump count (saturating) and last time
            if (rec.hit_count != HIT_MAX) begin
               rec_upd.hit_count = rec.hit_count + 16'd1;
            end
            rec_upd.last_time = now_ms;
            dec.rec_we        = 1'b1;
            dec.rec_wdata     = rec_upd;
         end else if (free_any) begin
            // Insert a new source; last time starts at zero
            dec.wr_idx               = free_idx;
            dec.rec_we               = 1'b1;
            dec.addr_we              = 1'b1;
            dec.valid_set            = 1'b1;
            dec.rec_wdata.hit_count  = 16'd1;
            dec.rec_wdata.first_time = now_ms;
            dec.rec_wdata.last_time  = '0;
            dec.rec_wdata.blocked    = 1'b0;
            dec.rec_wdata.block_time = '0;
         end else begin
            dec.rsp.table_full = 1'b1;
         end
      end else if (hit) begin
         if (rec.blocked) begin
            if (el_block >= rel_thr_ff) begin
               dec.valid_clr    = 1'b1;
               dec.rsp.released = 1'b1;
            end else begin
               dec.rsp.allowed = 1'b0;
            end
         end else if (el_first < win_thr_ff) begin
            if (rec.hit_count >= cfg.hit_limit) begin
               rec_upd.blocked       = 1'b1;
               rec_upd.block_time    = now_ms;
               dec.rec_we            = 1'b1;
               dec.rec_wdata         = rec_upd;
               dec.rsp.allowed       = 1'b0;
               dec.rsp.newly_blocked = 1'b1;
            end
         end else if (el_last >= idle_thr_ff) begin
            dec.valid_clr = 1'b1;
         end
      end
   end

endmodule
`default_nettype wire
